// ----- design/assert_macros.svh -----
// assertion helper macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is high
`define PDS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// clocked assertion that also holds during reset
`define PDS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- design/pds_pkg.sv -----
// -----------------------------------------------------------------------------
// pds_pkg
// Shared types and constants of the periodic deadline scheduler.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pds_pkg;

   // fixed widths
   localparam int TIME_BITS      = 48;
   localparam int IDX_MAX_BITS   = 8;
   localparam int OUT_INDEX_BITS = 4;
   localparam int MAX_FIRE       = 16;
   localparam int COUNT_BITS     = $clog2(MAX_FIRE + 1);

   // parameter defaults
   localparam int DEF_ENTRIES     = 16;
   localparam int DEF_PERIOD_BITS = 32;

   // command codes
   localparam logic [1:0] CMD_TICK   = 2'd0;
   localparam logic [1:0] CMD_ADD    = 2'd1;
   localparam logic [1:0] CMD_REMOVE = 2'd2;

   // candidate handed from cell to cell during a sweep
   typedef struct packed {
      logic                    valid;
      logic [TIME_BITS-1:0]    expiry;
      logic [IDX_MAX_BITS-1:0] idx;
   } cand_type;

   // control broadcast from the sequencer to every cell
   typedef struct packed {
      logic                    add;
      logic                    remove;
      logic                    fire;
      logic                    clear_done;
      logic [IDX_MAX_BITS-1:0] idx;
      logic [TIME_BITS-1:0]    period;
      logic [TIME_BITS-1:0]    now;
   } ctl_type;

endpackage

// ----- design/pds_cell.sv -----
// -----------------------------------------------------------------------------
// pds_cell
// One timer entry; compares itself against the candidate passed from the
// previous cell and hands the earlier due entry to the next cell.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pds_cell #(
   parameter int INDEX       = 0,
   parameter int PERIOD_BITS = pds_pkg::DEF_PERIOD_BITS
) (
   input  logic              clock,
   input  logic              reset,
   input  pds_pkg::ctl_type  ctl,
   input  pds_pkg::cand_type cand_in,
   output pds_pkg::cand_type cand_out
);

   logic                           valid_ff, valid_in;
   logic                           done_ff, done_in;
   logic [PERIOD_BITS-1:0]         period_ff, period_in;
   logic [pds_pkg::TIME_BITS-1:0]  expiry_ff, expiry_in;
   pds_pkg::cand_type              cand_ff, cand_in_w;
   logic                           sel;
   logic                           elig;
   logic                           take;

   assign sel = (ctl.idx == pds_pkg::IDX_MAX_BITS'(INDEX));

   // entry update from add, remove and fire
   always_comb begin
      valid_in  = valid_ff;
      done_in   = done_ff;
      period_in = period_ff;
      expiry_in = expiry_ff;
      if (ctl.clear_done) begin
         done_in = 1'b0;
      end
      if (sel && ctl.add) begin
         valid_in  = 1'b1;
         period_in = ctl.period[PERIOD_BITS-1:0];
         expiry_in = ctl.now + pds_pkg::TIME_BITS'(ctl.period[PERIOD_BITS-1:0]);
      end
      if (sel && ctl.remove) begin
         valid_in = 1'b0;
      end
      if (sel && ctl.fire) begin
         done_in   = 1'b1;
         expiry_in = ctl.now + pds_pkg::TIME_BITS'(period_ff);
      end
   end

   // keep earlier candidate; ties stay with the lower index upstream
   assign elig = valid_ff && !done_ff && (expiry_ff <= ctl.now);
   assign take = elig && (!cand_in.valid || (expiry_ff < cand_in.expiry));

   always_comb begin
      cand_in_w = cand_in;
      if (take) begin
         cand_in_w.valid  = 1'b1;
         cand_in_w.expiry = expiry_ff;
         cand_in_w.idx    = pds_pkg::IDX_MAX_BITS'(INDEX);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= 1'b0;
         done_ff       <= 1'b0;
         cand_ff.valid <= 1'b0;
      end else begin
         valid_ff      <= valid_in;
         done_ff       <= done_in;
         cand_ff.valid <= cand_in_w.valid;
      end
      period_ff      <= period_in;
      expiry_ff      <= expiry_in;
      cand_ff.expiry <= cand_in_w.expiry;
      cand_ff.idx    <= cand_in_w.idx;
   end

   assign cand_out = cand_ff;

endmodule

// ----- design/periodic_deadline_scheduler.sv -----
// -----------------------------------------------------------------------------
// periodic_deadline_scheduler
// Table of periodic timers with a tick counter, firing due entries in order.
// -----------------------------------------------------------------------------
// Usage: a request word carries a command (tick, add, remove), an entry index
// and a period. Add, remove and unused codes give one response word (fired = 0,
// last = 1) in the cycle after acceptance. A tick advances the counter and
// then runs sweeps along a chain of ENTRIES cells; each sweep picks the
// earliest due entry, ties to the lowest index. A tick that fires k entries
// gives k words, the final one with last = 1; one that fires none gives a
// single no-fire word.
// One request is in work at a time; a new one is taken once the previous
// request has delivered its final word into the output register and that
// register is empty or being read in the same cycle.
// Reset clears the counter and all armed entries.
// When the receiver stalls, the response register holds its word, the sweep
// sequencer waits before emitting the next one and no request is taken.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module periodic_deadline_scheduler #(
   parameter int ENTRIES     = pds_pkg::DEF_ENTRIES,
   parameter int PERIOD_BITS = pds_pkg::DEF_PERIOD_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [3:0]  req_entry_index,
   input  logic [31:0] req_period_ticks,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_fired,
   output logic [3:0]  rsp_fired_index,
   output logic        rsp_last
);

   localparam int CNT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SWEEP  = 2'd1;
   localparam logic [1:0] ST_DECIDE = 2'd2;

   logic [1:0]                        state_ff, state_in;
   logic [CNT_W-1:0]                  cnt_ff, cnt_in;
   logic [pds_pkg::TIME_BITS-1:0]     now_ff, now_in;
   logic                              held_ff, held_in;
   logic [pds_pkg::OUT_INDEX_BITS-1:0] held_idx_ff, held_idx_in;
   logic [pds_pkg::COUNT_BITS-1:0]    count_ff, count_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              rsp_fired_ff, rsp_fired_in;
   logic [pds_pkg::OUT_INDEX_BITS-1:0] rsp_idx_ff, rsp_idx_in;
   logic                              rsp_last_ff, rsp_last_in;

   pds_pkg::ctl_type  ctl;
   pds_pkg::cand_type cand_w [ENTRIES+1];
   pds_pkg::cand_type best;

   logic out_free;
   logic accept;
   logic found;
   logic need_emit;
   logic emit;
   logic emit_fired;
   logic emit_last;
   logic [pds_pkg::OUT_INDEX_BITS-1:0] emit_idx;

   // chain of entry cells
   assign cand_w[0] = '0;

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      pds_cell #(
         .INDEX       (i),
         .PERIOD_BITS (PERIOD_BITS)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .cand_in  (cand_w[i]),
         .cand_out (cand_w[i+1])
      );
   end

   assign best      = cand_w[ENTRIES];
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign accept    = req_valid && req_ready;
   assign found     = best.valid && (count_ff < pds_pkg::COUNT_BITS'(pds_pkg::MAX_FIRE));
   assign need_emit = held_ff || !found;

   // sweep sequencer
   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      now_in      = now_ff;
      held_in     = held_ff;
      held_idx_in = held_idx_ff;
      count_in    = count_ff;
      ctl         = '0;
      ctl.now     = now_ff;
      ctl.idx     = pds_pkg::IDX_MAX_BITS'(req_entry_index);
      ctl.period  = pds_pkg::TIME_BITS'(req_period_ticks);
      emit        = 1'b0;
      emit_fired  = 1'b0;
      emit_idx    = '0;
      emit_last   = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_command == pds_pkg::CMD_TICK) begin
                  now_in         = now_ff + pds_pkg::TIME_BITS'(1);
                  ctl.clear_done = 1'b1;
                  cnt_in         = '0;
                  held_in        = 1'b0;
                  count_in       = '0;
                  state_in       = ST_SWEEP;
               end else begin
                  ctl.add    = (req_command == pds_pkg::CMD_ADD);
                  ctl.remove = (req_command == pds_pkg::CMD_REMOVE);
                  emit       = 1'b1;
               end
            end
         end
         ST_SWEEP: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(ENTRIES - 1)) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (!need_emit || out_free) begin
               if (held_ff) begin
                  emit       = 1'b1;
                  emit_fired = 1'b1;
                  emit_idx   = held_idx_ff;
                  emit_last  = !found;
               end else if (!found) begin
                  emit = 1'b1;
               end
               if (found) begin
                  ctl.fire    = 1'b1;
                  ctl.idx     = best.idx;
                  held_in     = 1'b1;
                  held_idx_in = best.idx[pds_pkg::OUT_INDEX_BITS-1:0];
                  count_in    = count_ff + pds_pkg::COUNT_BITS'(1);
                  cnt_in      = '0;
                  state_in    = ST_SWEEP;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_fired_in = rsp_fired_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_fired_in = emit_fired;
         rsp_idx_in   = emit_idx;
         rsp_last_in  = emit_last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         now_ff       <= '0;
         held_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         now_ff       <= now_in;
         held_ff      <= held_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      held_idx_ff  <= held_idx_in;
      rsp_fired_ff <= rsp_fired_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_fired       = rsp_fired_ff;
   assign rsp_fired_index = rsp_idx_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

// ----- design/pds_checker.sv -----
// -----------------------------------------------------------------------------
// pds_checker
// Port-level checks of the periodic deadline scheduler, bound to the top.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pds_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [1:0]  req_command,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_fired,
   input logic [3:0]  rsp_fired_index,
   input logic        rsp_last
);

   logic cmd_accept;
   logic nofire_ok;

   // accepted word that is not a tick
   assign cmd_accept = req_valid && req_ready && (req_command != pds_pkg::CMD_TICK);

   // shape of a no-fire word
   assign nofire_ok = rsp_last && (rsp_fired_index == 4'd0);

   // a stalled word stays offered
   `PDS_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "rsp word dropped")

   // a no-fire word is always a lone final word with index zero
   `PDS_ASSERT(a_nofire_form, clock, reset, rsp_valid && !rsp_fired |-> nofire_ok, "bad no-fire word")

   // add, remove and unused commands answer in the next cycle
   `PDS_ASSERT(a_cmd_answer, clock, reset, cmd_accept |=> rsp_valid && !rsp_fired, "missing answer")

   // no word right after reset
   `PDS_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_valid, "rsp valid after reset")

endmodule

bind periodic_deadline_scheduler pds_checker u_pds_checker (.*);

// ----- sim/periodic_deadline_scheduler_test.sv -----
// -----------------------------------------------------------------------------
// periodic_deadline_scheduler_test
// Self-checking bench: drives tick, add, remove and unused words with random
// gaps and response stalls, predicts every response word from a behavioral
// copy of the timer table and counter and compares each word field by field.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module periodic_deadline_scheduler_test;

   localparam int NUM_ENTRIES = 16;
   localparam int CYCLE_LIMIT = 400000;

   // command code with no meaning
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0]  command;
      logic [3:0]  entry_index;
      logic [31:0] period_ticks;
   } req_word_type;

   typedef struct packed {
      logic       fired;
      logic [3:0] fired_index;
      logic       last;
   } rsp_word_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_command;
   logic [3:0]  req_entry_index;
   logic [31:0] req_period_ticks;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_fired;
   logic [3:0]  rsp_fired_index;
   logic        rsp_last;

   // timer table copy
   logic [47:0] sched_now;
   logic        sched_valid  [NUM_ENTRIES];
   logic [31:0] sched_period [NUM_ENTRIES];
   logic [47:0] sched_expiry [NUM_ENTRIES];

   req_word_type pending_words[$];
   rsp_word_type expected_words[$];
   int        error_count;
   int        cycle_count;
   int        words_sent;
   int        words_seen;
   int        fires_seen;
   int        send_wait;
   int        recv_wait;
   bit        drain_hold;
   bit        stimulus_done;

   periodic_deadline_scheduler i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_entry_index  (req_entry_index),
      .req_period_ticks (req_period_ticks),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_fired        (rsp_fired),
      .rsp_fired_index  (rsp_fired_index),
      .rsp_last         (rsp_last)
   );

   // update the table for one accepted word and queue its responses
   task automatic predict_schedule(input req_word_type w);
      bit           done [NUM_ENTRIES];
      int           count;
      int           best;
      rsp_word_type r;
      count = 0;
      if (w.command == pds_pkg::CMD_TICK) begin
         foreach (done[i]) done[i] = 0;
         sched_now = sched_now + 48'd1;
         while (count < pds_pkg::MAX_FIRE) begin
            best = -1;
            for (int i = 0; i < NUM_ENTRIES; i++) begin
               if (!sched_valid[i] || done[i] || sched_expiry[i] > sched_now) continue;
               if (best < 0 || sched_expiry[i] < sched_expiry[best]) best = i;
            end
            if (best < 0) break;
            done[best] = 1;
            sched_expiry[best] = sched_now + {16'd0, sched_period[best]};
            r.fired = 1'b1;
            r.fired_index = best[3:0];
            r.last = 1'b0;
            expected_words.push_back(r);
            count++;
         end
         if (count > 0) begin
            expected_words[expected_words.size()-1].last = 1'b1;
            return;
         end
      end else if (w.command == pds_pkg::CMD_ADD) begin
         sched_valid[w.entry_index]  = 1'b1;
         sched_period[w.entry_index] = w.period_ticks;
         sched_expiry[w.entry_index] = sched_now + {16'd0, w.period_ticks};
      end else if (w.command == pds_pkg::CMD_REMOVE) begin
         sched_valid[w.entry_index] = 1'b0;
      end
      r.fired = 1'b0;
      r.fired_index = 4'd0;
      r.last = 1'b1;
      expected_words.push_back(r);
   endtask

   function automatic req_word_type make_word(input logic [1:0] c, input int idx,
                                              input logic [31:0] p);
      req_word_type w;
      w.command = c;
      w.entry_index = idx[3:0];
      w.period_ticks = p;
      return w;
   endfunction

   function automatic logic [31:0] rand_period();
      case ($urandom_range(0, 9))
         0:       return $urandom();
         1:       return 32'd0;
         default: return $urandom_range(1, 6);
      endcase
   endfunction

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // stimulus
   initial begin
      // table copy starts from the reset state
      sched_now = '0;
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         sched_valid[i]  = 1'b0;
         sched_period[i] = '0;
         sched_expiry[i] = '0;
      end
      reset = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      // directed: extremes, every command, unused code, zero period, overload
      pending_words.push_back(make_word(pds_pkg::CMD_TICK, 0, 0));
      pending_words.push_back(make_word(pds_pkg::CMD_REMOVE, 15, 32'hFFFFFFFF));
      pending_words.push_back(make_word(pds_pkg::CMD_ADD, 0, 32'd0));
      pending_words.push_back(make_word(pds_pkg::CMD_ADD, 15, 32'hFFFFFFFF));
      pending_words.push_back(make_word(pds_pkg::CMD_ADD, 5, 32'hAAAAAAAA));
      pending_words.push_back(make_word(pds_pkg::CMD_ADD, 5, 32'h55555555));
      pending_words.push_back(make_word(CMD_UNUSED, 10, 32'd1));
      pending_words.push_back(make_word(pds_pkg::CMD_TICK, 3, 0));
      pending_words.push_back(make_word(pds_pkg::CMD_REMOVE, 15, 0));
      pending_words.push_back(make_word(pds_pkg::CMD_REMOVE, 5, 0));
      for (int i = 0; i < NUM_ENTRIES; i++)
         pending_words.push_back(make_word(pds_pkg::CMD_ADD, i, (i % 2) ? 32'd1 : 32'd0));
      pending_words.push_back(make_word(pds_pkg::CMD_TICK, 0, 0));
      pending_words.push_back(make_word(pds_pkg::CMD_TICK, 0, 0));
      // random: mostly arm then tick
      for (int n = 0; n < 82; n++) begin
         case ($urandom_range(0, 9))
            0, 1, 2: pending_words.push_back(make_word(pds_pkg::CMD_ADD,
                                                      $urandom_range(0, 15),
                                                      rand_period()));
            3:       pending_words.push_back(make_word(pds_pkg::CMD_REMOVE,
                                                      $urandom_range(0, 15),
                                                      $urandom()));
            4:       pending_words.push_back(make_word(CMD_UNUSED, $urandom_range(0, 15),
                                                      $urandom()));
            default: pending_words.push_back(make_word(pds_pkg::CMD_TICK,
                                                      $urandom_range(0, 15),
                                                      $urandom()));
         endcase
      end
   end

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_command <= 2'd0;
         req_entry_index <= 4'd0;
         req_period_ticks <= 32'd0;
         send_wait <= 0;
         words_sent <= 0;
         drain_hold <= 1'b0;
         stimulus_done <= 1'b0;
      end else begin
         logic accepted;
         accepted = req_valid && req_ready;
         if (accepted) begin
            predict_schedule({req_command, req_entry_index, req_period_ticks});
            words_sent <= words_sent + 1;
            send_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            // one hold until the response queue is empty
            if (words_sent == 60) drain_hold <= 1'b1;
         end
         if (req_valid && !accepted) begin
            // hold the word
         end else if (drain_hold && expected_words.size() != 0) begin
            req_valid <= 1'b0;
         end else if (!accepted && send_wait > 0) begin
            req_valid <= 1'b0;
            send_wait <= send_wait - 1;
            drain_hold <= 1'b0;
         end else if (!accepted && pending_words.size() != 0) begin
            req_word_type w;
            w = pending_words.pop_front();
            req_valid <= 1'b1;
            {req_command, req_entry_index, req_period_ticks} <= w;
            drain_hold <= 1'b0;
         end else begin
            req_valid <= 1'b0;
            if (!accepted && pending_words.size() == 0) stimulus_done <= 1'b1;
         end
      end
   end

   // monitor and response stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_wait <= 0;
         words_seen <= 0;
         fires_seen <= 0;
         error_count <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            words_seen <= words_seen + 1;
            if (expected_words.size() == 0) begin
               $error("unexpected response word");
               error_count <= error_count + 1;
            end else begin
               rsp_word_type e;
               e = expected_words.pop_front();
               fires_seen <= fires_seen + e.fired;
               if (rsp_fired !== e.fired) begin
                  $error("fired: expected %0d actual %0d", e.fired, rsp_fired);
                  error_count <= error_count + 1;
               end
               if (rsp_fired_index !== e.fired_index) begin
                  $error("fired_index: expected %0d actual %0d", e.fired_index,
                         rsp_fired_index);
                  error_count <= error_count + 1;
               end
               if (rsp_last !== e.last) begin
                  $error("last: expected %0d actual %0d", e.last, rsp_last);
                  error_count <= error_count + 1;
               end
            end
            recv_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            rsp_ready <= 1'b0;
         end else if (recv_wait > 0) begin
            recv_wait <= recv_wait - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // end of run and cycle limit
   initial begin
      cycle_count = 0;
      @(negedge clock);
      while (!(stimulus_done && expected_words.size() == 0) && cycle_count < CYCLE_LIMIT) begin
         @(negedge clock);
         cycle_count++;
      end
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         repeat (40) @(negedge clock);
         $display("sent %0d request words, checked %0d response words, %0d firings",
                  words_sent, words_seen, fires_seen);
         if (error_count == 0 && expected_words.size() == 0) begin
            $display("TB_OK");
         end else begin
            $display("TB_ERROR");
         end
         $finish;
      end
   end

endmodule
